// ===== design/b32_pkg.sv =====
package b32_pkg;

  // Bit widths of the decoder datapath.
  localparam int SymW  = 5;
  localparam int BufW  = 7;
  localparam int CntW  = 3;
  localparam int ByteW = 8;

  // Class of one incoming character.
  typedef enum logic [1:0] {
    CLS_SYMBOL,
    CLS_SPACE,
    CLS_BAD
  } cls_t;

  // Classified character as it travels from the front end to the back end.
  typedef struct packed {
    cls_t            cls;
    logic [SymW-1:0] sym;
    logic            last;
  } b32_item_t;

  // One result transaction.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             byte_valid;
    logic             done;
    logic             ok;
  } b32_result_t;

  // Character codes used by the classifier.
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChEight  = 8'h38;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // Symbol values that the look-alike digits stand for (O, L, B, G).
  localparam logic [SymW-1:0] SymO = 5'd14;
  localparam logic [SymW-1:0] SymL = 5'd11;
  localparam logic [SymW-1:0] SymB = 5'd1;
  localparam logic [SymW-1:0] SymG = 5'd6;
  localparam logic [SymW-1:0] SymDigitBase = 5'd26;

  // Map a character to its class and, for symbols, its 5-bit value.
  function automatic b32_item_t classify(input logic [7:0] c, input logic last);
    b32_item_t it;
    it.cls  = CLS_BAD;
    it.sym  = '0;
    it.last = last;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymW'(c - ChUpperA);
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymW'(c - ChLowerA);
    end else if (c >= ChTwo && c <= ChSeven) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymW'(c - ChTwo) + SymDigitBase;
    end else if (c == ChZero) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymO;
    end else if (c == ChOne) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymL;
    end else if (c == ChEight) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymB;
    end else if (c == ChNine) begin
      it.cls = CLS_SYMBOL;
      it.sym = SymG;
    end else if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
      it.cls = CLS_SPACE;
    end
    return it;
  endfunction

endpackage

// ===== design/b32_front.sv =====
module b32_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // char_in
  input  logic                s_tlast,   // is_last
  output b32_pkg::b32_item_t  item,
  output logic                item_valid,
  input  logic                item_ready
);
  import b32_pkg::*;

  logic      hold_valid;
  b32_item_t hold_item;

  // The holding register refills whenever it is empty or being handed on.
  assign s_tready   = !hold_valid || item_ready;
  assign item       = hold_item;
  assign item_valid = hold_valid;

  // Classify each accepted character into the holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
      if (s_tvalid) begin
        hold_item <= classify(s_tdata, s_tlast);
      end
    end
  end

endmodule

// ===== design/b32_queue.sv =====
module b32_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  b32_pkg::b32_item_t  push_item,
  input  logic                push_valid,
  output logic                push_ready,
  output b32_pkg::b32_item_t  pop_item,
  output logic                pop_valid,
  input  logic                pop_ready
);
  import b32_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b32_item_t      slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/b32_back.sv =====
module b32_back (
  input  logic                 clk,
  input  logic                 rst,
  input  b32_pkg::b32_item_t   item,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 res_valid,
  input  logic                 res_ready,
  output b32_pkg::b32_result_t res
);
  import b32_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DECODE,
    PH_ERROR
  } phase_t;

  localparam int AccW = BufW + SymW;
  localparam int NW   = CntW + 1;

  phase_t           phase;
  phase_t           phase_next;
  logic [BufW-1:0]  bit_buf;
  logic [BufW-1:0]  bit_buf_next;
  logic [CntW-1:0]  bit_cnt;
  logic [CntW-1:0]  bit_cnt_next;
  logic [AccW-1:0]  acc;
  logic [AccW-1:0]  acc_kept;
  logic [NW-1:0]    n_sum;
  logic [NW-1:0]    n_rem;
  logic             have_byte;
  logic [ByteW-1:0] byte_val;
  logic             emit;
  logic             ok;
  logic             take;

  // An item is retired whenever the output register is free or draining.
  assign item_ready = !res_valid || res_ready;
  assign take       = item_valid && item_ready;

  // Shift the symbol into the bit buffer and peel off a full byte.
  always_comb begin
    acc      = {bit_buf, item.sym};
    n_sum    = NW'(bit_cnt) + NW'(SymW);
    n_rem    = n_sum - NW'(ByteW);
    byte_val = ByteW'(acc >> n_rem);
    acc_kept = acc & ((AccW'(1) << n_rem) - AccW'(1));
  end

  // Next state of the decoder for the item at the head of the queue.
  always_comb begin
    phase_next   = phase;
    bit_buf_next = bit_buf;
    bit_cnt_next = bit_cnt;
    have_byte    = 1'b0;
    case (phase)
      PH_LEAD: begin
        if (item.cls == CLS_SYMBOL) begin
          bit_buf_next = BufW'(item.sym);
          bit_cnt_next = CntW'(SymW);
          phase_next   = PH_DECODE;
        end else if (item.cls != CLS_SPACE) begin
          phase_next = PH_ERROR;
        end
      end
      PH_DECODE: begin
        if (item.cls == CLS_SYMBOL) begin
          if (n_sum >= NW'(ByteW)) begin
            have_byte    = 1'b1;
            bit_buf_next = acc_kept[BufW-1:0];
            bit_cnt_next = n_rem[CntW-1:0];
          end else begin
            bit_buf_next = acc[BufW-1:0];
            bit_cnt_next = n_sum[CntW-1:0];
          end
        end else begin
          phase_next = PH_ERROR;
        end
      end
      default: begin
      end
    endcase
    emit = have_byte || item.last;
    ok   = item.last && (phase_next == PH_LEAD || phase_next == PH_DECODE);
    // The last character returns the decoder to its idle state.
    if (item.last) begin
      phase_next   = PH_LEAD;
      bit_buf_next = '0;
      bit_cnt_next = '0;
    end
  end

  // Decoder state and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      bit_buf   <= '0;
      bit_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        phase   <= phase_next;
        bit_buf <= bit_buf_next;
        bit_cnt <= bit_cnt_next;
        if (emit) begin
          res_valid      <= 1'b1;
          res.data       <= have_byte ? byte_val : '0;
          res.byte_valid <= have_byte;
          res.done       <= item.last;
          res.ok         <= ok;
        end
      end
    end
  end

endmodule

// ===== design/base32_lenient_decoder_unit.sv =====
// Lenient base32 text decoder.
// The input stream carries one ASCII character per transaction in s_tdata,
// with s_tlast on the final character of a string. Leading whitespace is
// skipped; after that every character must be a symbol (A-Z, 2-7, lower
// case, and 0/1/8/9 read as O/L/B/G) or the string is in error.
// The output stream carries a transaction whenever a byte completes or the
// string ends: m_tdata is the byte (zero when there is none), m_tuser[0]
// says a byte is present, m_tlast marks the end of the string and
// m_tuser[1] then reports a clean decode. Leftover bits are dropped.
// Throughput is one character per cycle while m_tready stays high. An
// input transaction reaches m_tvalid through a classify register, the item
// queue and the output register of the decoder state machine.
// Reset clears the queue, the output register and the decoder state.
// When m_tready is low the back end holds its result and stops draining
// the queue; the front end keeps accepting until the queue fills, then
// drops s_tready. Characters with no result update state only.
module base32_lenient_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tlast,   // is_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] decode_ok
  output logic       m_tlast    // done_res
);
  import b32_pkg::*;

  b32_item_t   front_item;
  logic        front_valid;
  logic        queue_ready;
  b32_item_t   head_item;
  logic        head_valid;
  logic        head_ready;
  b32_result_t res;

  // Character classification.
  b32_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (queue_ready)
  );

  // Decoupling queue between classification and decoding.
  b32_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .pop_item   (head_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready)
  );

  // Bit gathering and result generation.
  b32_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (head_item),
    .item_valid (head_valid),
    .item_ready (head_ready),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  // Result fields onto the output stream.
  assign m_tdata = res.data;
  assign m_tuser = {res.ok, res.byte_valid};
  assign m_tlast = res.done;

endmodule

// ===== design/b32_checker.sv =====
module b32_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
    else $error("output transaction changed while stalled");

  // Every result carries a byte, an end of string, or both.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] || m_tlast)
    else $error("empty output transaction");

  // A clean-decode flag only appears on the end of a string.
  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tuser[1])
    else $error("decode_ok without done");

  // Without a byte the data field is zero.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
    else $error("data present without byte_valid");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind base32_lenient_decoder_unit b32_checker u_b32_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b32_pkg::*;

  // Decoder phases of the predictor.
  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SYMBOLS,
    PH_FAILED
  } dec_phase_t;

  // One character waiting to be sent.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  localparam int unsigned CycleLimit = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  char_item_t  tx_chars[$];
  b32_result_t expected_results[$];
  bit          quiet = 1'b0;
  int          err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;

  // Predictor state.
  dec_phase_t dec_phase = PH_SKIP;
  logic [6:0] dec_bits = '0;
  logic [2:0] dec_nbits = '0;

  base32_lenient_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Symbol lookup: returns 1 and the 5-bit value for a base32 symbol.
  function automatic bit symbol_of(input logic [7:0] c, output logic [4:0] v);
    v = '0;
    if (c >= "A" && c <= "Z") v = 5'(c - "A");
    else if (c >= "a" && c <= "z") v = 5'(c - "a");
    else if (c >= "2" && c <= "7") v = 5'(c - "2") + 5'd26;
    else if (c == "0") v = 5'd14;
    else if (c == "1") v = 5'd11;
    else if (c == "8") v = 5'd1;
    else if (c == "9") v = 5'd6;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Advance the predicted decoder by one character and report any result.
  task automatic decode_char(input logic [7:0] c, input logic last, output bit emit,
                             output b32_result_t res);
    logic [4:0]  v;
    bit          is_sym;
    logic [11:0] acc;
    int unsigned n;
    bit          have;
    logic [7:0]  data;
    have = 1'b0;
    data = '0;
    is_sym = symbol_of(c, v);
    if (dec_phase == PH_SKIP) begin
      if (is_sym) begin
        dec_bits = {2'b00, v};
        dec_nbits = 3'd5;
        dec_phase = PH_SYMBOLS;
      end else if (!is_blank(c)) begin
        dec_phase = PH_FAILED;
      end
    end else if (dec_phase == PH_SYMBOLS) begin
      if (is_sym) begin
        acc = {dec_bits, v};
        n = dec_nbits + 5;
        if (n >= 8) begin
          n -= 8;
          data = 8'(acc >> n);
          acc &= (12'd1 << n) - 12'd1;
          have = 1'b1;
        end
        dec_bits = acc[6:0];
        dec_nbits = 3'(n);
      end else begin
        dec_phase = PH_FAILED;
      end
    end
    emit = have || last;
    res.data = data;
    res.byte_valid = have;
    res.done = last;
    res.ok = last && dec_phase != PH_FAILED;
    if (last) begin
      dec_phase = PH_SKIP;
      dec_bits = '0;
      dec_nbits = '0;
    end
  endtask

  // Sender: one transaction per handshake, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tlast <= 1'b0;
      src_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(0, 5);
        s_tvalid <= 1'b0;
      end else if (tx_chars.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= tx_chars[0].ch;
        s_tlast <= tx_chars[0].last;
        void'(tx_chars.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready with random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: check each result transaction, then predict from each input one.
  always @(posedge clk) begin
    b32_result_t want;
    bit          emit;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: out_byte %0h, tuser %0b, tlast %0b",
                 m_tdata, m_tuser, m_tlast);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
            err_count++;
          end
          if (m_tuser[0] !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_tuser[0]);
            err_count++;
          end
          if (m_tlast !== want.done) begin
            $error("done_res: expected %0b, got %0b", want.done, m_tlast);
            err_count++;
          end
          if (m_tuser[1] !== want.ok) begin
            $error("decode_ok: expected %0b, got %0b", want.ok, m_tuser[1]);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        decode_char(s_tdata, s_tlast, emit, want);
        if (emit) expected_results.insert(expected_results.size(), want);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rand_symbol();
    logic [7:0] digits[4];
    digits = '{"0", "1", "8", "9"};
    case ($urandom_range(0, 4))
      0, 1: return 8'("A" + $urandom_range(0, 25));
      2: return 8'("a" + $urandom_range(0, 25));
      3: return 8'("2" + $urandom_range(0, 5));
      default: return digits[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'(8'h08 + r);
  endfunction

  function automatic logic [7:0] rand_bad();
    logic [7:0] c;
    logic [4:0] v;
    do c = 8'($urandom_range(0, 255)); while (symbol_of(c, v) || is_blank(c));
    return c;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.ch = c;
    it.last = last;
    tx_chars.insert(tx_chars.size(), it);
  endtask

  // Queue one random string and return its length in characters.
  task automatic add_string(output int unsigned len);
    logic [7:0]  s[$];
    int unsigned kind;
    int unsigned lead;
    int unsigned nsym;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      // Pure noise bytes.
      repeat ($urandom_range(1, 8)) s.insert(s.size(), 8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 4)) s.insert(s.size(), rand_blank());
    end else begin
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      nsym = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      repeat (lead) s.insert(s.size(), rand_blank());
      repeat (nsym) s.insert(s.size(), rand_symbol());
      if (kind <= 4) begin
        // Broken string: a stray character after the first symbol, or a bad one up front.
        if ($urandom_range(0, 3) == 0)
          s.insert($urandom_range(0, lead), rand_bad());
        else
          s.insert($urandom_range(lead + 1, s.size()),
                   $urandom_range(0, 1) ? rand_blank() : rand_bad());
      end
    end
    foreach (s[i]) push_char(s[i], i == s.size() - 1);
    len = s.size();
  endtask

  task automatic add_random(input int unsigned target);
    int unsigned total;
    int unsigned len;
    total = 0;
    while (total < target) begin
      add_string(len);
      total += len;
    end
  endtask

  // Block the caller until every queued character is sent and every result is in.
  task automatic wait_drained();
    do @(negedge clk);
    while (tx_chars.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // All-whitespace string.
    push_char(8'h20, 1'b1);
    // Leading whitespace, every symbol form, last character completes a byte.
    push_char(8'h09, 1'b0);
    push_char(8'h0D, 1'b0);
    push_char("a", 1'b0);
    push_char("Z", 1'b0);
    push_char("2", 1'b0);
    push_char("7", 1'b0);
    push_char("0", 1'b0);
    push_char("1", 1'b0);
    push_char("8", 1'b0);
    push_char("9", 1'b1);
    // Unknown character before the first symbol.
    push_char(8'h00, 1'b0);
    push_char("A", 1'b1);
    // Whitespace after a symbol is an error and suppresses later bytes.
    push_char("A", 1'b0);
    push_char("B", 1'b0);
    push_char(8'h20, 1'b0);
    push_char("C", 1'b0);
    push_char("D", 1'b1);
    // Single unknown high byte, and a high byte after a symbol.
    push_char(8'hFF, 1'b1);
    push_char("Q", 1'b0);
    push_char(8'h80, 1'b1);
    wait_drained();

    add_random(300);
    wait_drained();
    add_random(300);
    wait_drained();

    // Final stretch without any idling.
    quiet = 1'b1;
    add_random(100);
    wait_drained();
    repeat (12) @(negedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/b32_pkg.sv
design/b32_front.sv
design/b32_queue.sv
design/b32_back.sv
design/base32_lenient_decoder_unit.sv
design/b32_checker.sv
test/tb_top.sv
